### design/cfir_pkg.sv
// shared types and constants for the complex fir filter
package cfir_pkg;

    // transaction kind carried on the input channel
    typedef enum logic [0:0] {
        KIND_SAMPLE = 1'b0,
        KIND_COEF   = 1'b1
    } t_kind;

    // configuration register map
    localparam int  CFG_ADDR_W       = 3;
    localparam int  CFG_DATA_W       = 32;
    localparam int  SHIFT_W          = 6;
    localparam logic REG_OUTPUT_SHIFT = 1'b0;
    localparam logic [SHIFT_W-1:0] OUTPUT_SHIFT_RESET = 6'd15;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX          = 6'd62;

    // width of the rounding and shifting datapath
    localparam int  WIDE_W = 64;

    // width of the tap index field
    localparam int  TAP_IDX_W = 6;

endpackage

### design/cfir_in_if.sv
// input channel: samples and coefficient writes
interface cfir_in_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
);
    import cfir_pkg::*;

    logic                          valid;
    logic                          ready;
    t_kind                         kind;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic [TAP_IDX_W-1:0]          tap_index;
    logic signed [COEF_BITS-1:0]   tap_re;
    logic signed [COEF_BITS-1:0]   tap_im;

    modport source (output valid, kind, sample_re, sample_im, tap_index, tap_re, tap_im,
                    input ready);
    modport sink   (input valid, kind, sample_re, sample_im, tap_index, tap_re, tap_im,
                    output ready);
endinterface

### design/cfir_out_if.sv
// output channel: filtered samples
interface cfir_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_re;
    logic signed [SAMPLE_BITS-1:0] out_im;
    logic                          saturated;

    modport source (output valid, out_re, out_im, saturated, input ready);
    modport sink   (input valid, out_re, out_im, saturated, output ready);
endinterface

### design/cfir_ram.sv
// generic single write port, single read port ram with registered read
module cfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/complex_fir_filter_unit.sv
// complex fir filter: circular sample history, complex taps, shared complex mac
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-----------------------------------------
//  i_in     | in  | valid/ready            | kind, sample_re/im, tap_index, tap_re/im
//  o_out    | out | valid/ready            | out_re, out_im, saturated
//  apb      | in  | psel/penable, pready=1 | output_shift at byte address 0
//
//  a sample runs one complex mac per tap on the shared complex multiplier, fed by
//  one read port of each ram, then drains, rounds, shifts and saturates
//  a coefficient write gives no result
//  after reset a clearing pass zeroes both rams; no input is taken meanwhile
//  a result waiting on o_out does not block the next input transaction; only the final
//  output load waits for the output register to free up
module complex_fir_filter_unit #(
    parameter int TAPS        = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cfir_in_if.sink                         i_in,
    cfir_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cfir_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cfir_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cfir_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import cfir_pkg::*;

    localparam int AW     = $clog2(TAPS);
    localparam int PW     = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PW + 1 + $clog2(TAPS);
    localparam int HIST_W = 2 * SAMPLE_BITS;
    localparam int TAP_W  = 2 * COEF_BITS;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
    localparam logic signed [WIDE_W-1:0] SAT_HI = (WIDE_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - 1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_WRITE = 8'b0000_0100,
        ST_MAC   = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_ROUND = 8'b0010_0000,
        ST_SHIFT = 8'b0100_0000,
        ST_SAT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [SHIFT_W-1:0] r_output_shift;
    logic [AW-1:0]      r_wp;
    logic [AW-1:0]      r_rd_ptr;
    logic [AW-1:0]      r_cnt;
    logic               r_rd_vld;
    logic               r_prod_vld;
    logic               r_out_valid;

    // captured transaction
    t_kind                         r_kind;
    logic signed [SAMPLE_BITS-1:0] r_s_re, r_s_im;
    logic [TAP_IDX_W-1:0]          r_tap_idx;
    logic signed [COEF_BITS-1:0]   r_t_re, r_t_im;

    // datapath
    logic signed [PW-1:0]     r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;
    logic signed [WIDE_W-1:0] r_wide_re, r_wide_im;
    logic signed [SAMPLE_BITS-1:0] r_out_re, r_out_im;
    logic                          r_out_sat;

    // ram ports
    logic              hist_we, tap_we;
    logic [AW-1:0]     hist_waddr, tap_waddr;
    logic [HIST_W-1:0] hist_wdata, hist_q;
    logic [TAP_W-1:0]  tap_wdata, tap_q;

    logic signed [SAMPLE_BITS-1:0] h_re, h_im;
    logic signed [COEF_BITS-1:0]   c_re, c_im;
    logic [SHIFT_W-1:0]            shift_amt;
    logic signed [WIDE_W-1:0]      rnd;
    logic signed [SAMPLE_BITS-1:0] sat_re, sat_im;
    logic                          clip_re, clip_im;
    logic                          in_fire, out_fire, cfg_write, tap_in_range, last_tap;

    assign in_fire      = i_in.valid && i_in.ready;
    assign out_fire     = o_out.valid && o_out.ready;
    assign cfg_write    = psel && penable && pwrite && pready;
    assign tap_in_range = 32'(r_tap_idx) < TAPS;
    assign last_tap     = r_cnt == LAST;

    assign i_in.ready      = r_state == ST_IDLE;
    assign o_out.valid     = r_out_valid;
    assign o_out.out_re    = r_out_re;
    assign o_out.out_im    = r_out_im;
    assign o_out.saturated = r_out_sat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUTPUT_SHIFT) ? CFG_DATA_W'(r_output_shift) : '0;

    // ram write selection: clearing pass or captured transaction
    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = r_wp;
        hist_wdata = {r_s_re, r_s_im};
        tap_we     = 1'b0;
        tap_waddr  = AW'(r_tap_idx);
        tap_wdata  = {r_t_re, r_t_im};
        if (r_state == ST_CLEAR) begin
            hist_we    = 1'b1;
            hist_waddr = r_cnt;
            hist_wdata = '0;
            tap_we     = 1'b1;
            tap_waddr  = r_cnt;
            tap_wdata  = '0;
        end else if (r_state == ST_WRITE) begin
            hist_we = r_kind == KIND_SAMPLE;
            tap_we  = (r_kind == KIND_COEF) && tap_in_range;
        end
    end

    cfir_ram #(.WIDTH(HIST_W), .DEPTH(TAPS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (r_rd_ptr),
        .o_rdata (hist_q)
    );

    cfir_ram #(.WIDTH(TAP_W), .DEPTH(TAPS)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata (tap_wdata),
        .i_raddr (r_cnt),
        .o_rdata (tap_q)
    );

    assign h_re = hist_q[HIST_W-1:SAMPLE_BITS];
    assign h_im = hist_q[SAMPLE_BITS-1:0];
    assign c_re = tap_q[TAP_W-1:COEF_BITS];
    assign c_im = tap_q[COEF_BITS-1:0];

    assign shift_amt = (r_output_shift > SHIFT_MAX) ? SHIFT_MAX : r_output_shift;
    assign rnd = (shift_amt == '0) ? '0 : (WIDE_W'(1) <<< (shift_amt - 1'b1));

    // saturation to the output width
    always_comb begin
        clip_re = 1'b0;
        clip_im = 1'b0;
        sat_re  = SAMPLE_BITS'(r_wide_re);
        sat_im  = SAMPLE_BITS'(r_wide_im);
        if (r_wide_re > SAT_HI) begin
            sat_re  = SAMPLE_BITS'(SAT_HI);
            clip_re = 1'b1;
        end else if (r_wide_re < SAT_LO) begin
            sat_re  = SAMPLE_BITS'(SAT_LO);
            clip_re = 1'b1;
        end
        if (r_wide_im > SAT_HI) begin
            sat_im  = SAMPLE_BITS'(SAT_HI);
            clip_im = 1'b1;
        end else if (r_wide_im < SAT_LO) begin
            sat_im  = SAMPLE_BITS'(SAT_LO);
            clip_im = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (last_tap) n_state = ST_IDLE;
            ST_IDLE:  if (in_fire) n_state = ST_WRITE;
            ST_WRITE: n_state = (r_kind == KIND_SAMPLE) ? ST_MAC : ST_IDLE;
            ST_MAC:   if (last_tap) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_rd_vld && !r_prod_vld) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_SHIFT;
            ST_SHIFT: n_state = ST_SAT;
            ST_SAT:   if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_output_shift <= OUTPUT_SHIFT_RESET;
            r_wp           <= '0;
            r_rd_ptr       <= '0;
            r_cnt          <= '0;
            r_rd_vld       <= 1'b0;
            r_prod_vld     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= r_state == ST_MAC;
            r_prod_vld <= r_rd_vld;
            if (cfg_write && paddr[2] == REG_OUTPUT_SHIFT) begin
                r_output_shift <= pwdata[SHIFT_W-1:0];
            end
            if (r_state == ST_CLEAR || r_state == ST_MAC) begin
                r_cnt <= last_tap ? '0 : r_cnt + 1'b1;
            end
            if (r_state == ST_MAC) begin
                // walk the history backwards from the newest sample
                r_rd_ptr <= (r_rd_ptr == '0) ? LAST : r_rd_ptr - 1'b1;
            end
            if (r_state == ST_WRITE && r_kind == KIND_SAMPLE) begin
                r_rd_ptr <= r_wp;
                r_cnt    <= '0;
                r_wp     <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (r_state == ST_SAT && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind    <= i_in.kind;
            r_s_re    <= i_in.sample_re;
            r_s_im    <= i_in.sample_im;
            r_tap_idx <= i_in.tap_index;
            r_t_re    <= i_in.tap_re;
            r_t_im    <= i_in.tap_im;
        end
        if (r_rd_vld) begin
            r_p_rr <= PW'(h_re * c_re);
            r_p_ii <= PW'(h_im * c_im);
            r_p_ri <= PW'(h_re * c_im);
            r_p_ir <= PW'(h_im * c_re);
        end
        if (r_state == ST_WRITE) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_prod_vld) begin
            r_acc_re <= r_acc_re + ACC_W'(r_p_rr) - ACC_W'(r_p_ii);
            r_acc_im <= r_acc_im + ACC_W'(r_p_ri) + ACC_W'(r_p_ir);
        end
        if (r_state == ST_ROUND) begin
            r_wide_re <= WIDE_W'(r_acc_re) + rnd;
            r_wide_im <= WIDE_W'(r_acc_im) + rnd;
        end else if (r_state == ST_SHIFT) begin
            r_wide_re <= r_wide_re >>> shift_amt;
            r_wide_im <= r_wide_im >>> shift_amt;
        end
        if (r_state == ST_SAT && (!r_out_valid || o_out.ready)) begin
            r_out_re  <= sat_re;
            r_out_im  <= sat_im;
            r_out_sat <= clip_re || clip_im;
        end
    end

    // the clearing pass runs once after reset
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |=> (r_state != ST_CLEAR))
        else $error("clearing pass re-entered");

    // mac pipeline only carries data while a sample is being filtered
    a_pipe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld || r_prod_vld) |-> (r_state == ST_MAC || r_state == ST_DRAIN))
        else $error("mac pipeline active outside filtering");

    // the write pointer moves only on a sample transaction
    a_wp_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_wp)) |->
            ($past(r_state) == ST_WRITE && $past(r_kind) == KIND_SAMPLE))
        else $error("write pointer moved without a sample");

    // pointers stay inside the ram
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_wp) < TAPS) && (32'(r_rd_ptr) < TAPS))
        else $error("pointer outside tap range");

    // the last tap issue hands over to the drain phase
    a_mac_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC && last_tap) |=> (r_state == ST_DRAIN))
        else $error("mac phase did not end after the last tap");
endmodule
